>>> rtl/core/source_text_tokenizer_core_assert.svh
// assertion macros for the tokenizer rtl
`ifndef SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every clock outside reset
`define STT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// next-cycle implication
`define STT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`else

`define STT_ASSERT_IMP(lbl, ante, cons)
`define STT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/stt_pkg.sv
package stt_pkg;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       end_of_source;
   } stt_req_type;

   typedef struct packed {
      logic [7:0] tok_byte;
      logic       token_start;
      logic       token_end;
      logic [1:0] token_kind;
      logic       unterminated;
      logic       last_of_run;
   } stt_rsp_type;

   // token kinds
   localparam logic [1:0] KIND_STRING = 2'd0;
   localparam logic [1:0] KIND_PAIR   = 2'd1;
   localparam logic [1:0] KIND_PUNCT  = 2'd2;
   localparam logic [1:0] KIND_WORD   = 2'd3;

   // lexer modes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_STR  = 2'd1;
   localparam logic [1:0] MODE_WORD = 2'd2;
   localparam logic [1:0] MODE_PEND = 2'd3;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BAR   = 8'h7C;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // + - * / ( ) { } [ ] ; , < > = !
   function automatic logic is_punct(input logic [7:0] c);
      return c inside {CH_PLUS, CH_MINUS, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h7B, 8'h7D,
                       8'h5B, 8'h5D, 8'h3B, 8'h2C, CH_LT, CH_GT, CH_EQ, CH_BANG};
   endfunction

   function automatic logic is_pair_first(input logic [7:0] c);
      return c inside {CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_BAR, CH_PLUS, CH_MINUS};
   endfunction

   function automatic logic pair_forms(input logic [7:0] a, input logic [7:0] b);
      logic doubled;
      logic cmp;
      doubled = (a == b) && (a inside {CH_EQ, CH_AMP, CH_BAR, CH_PLUS, CH_MINUS});
      cmp     = (b == CH_EQ) && (a inside {CH_BANG, CH_LT, CH_GT});
      return doubled || cmp;
   endfunction

   function automatic stt_rsp_type mk_rsp(input logic [7:0] b, input logic s,
                                          input logic e, input logic [1:0] k,
                                          input logic u);
      stt_rsp_type r;
      r.tok_byte     = b;
      r.token_start  = s;
      r.token_end    = e;
      r.token_kind   = k;
      r.unterminated = u;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

endpackage

>>> rtl/core/source_text_tokenizer_core.sv
// channel   dir   ports                               payload
// request   in    req_valid, req_ready, req_data      stt_req_type: one source byte
// response  out   rsp_valid, rsp_ready, rsp_data      stt_rsp_type: one token byte
//
// one request per cycle while req_ready is high; each request yields zero, one or two responses
// a request that yields two responses writes both into the queue together
// responses sit in a three-slot shift queue; req_ready holds while at least two slots are free
// synchronous reset clears mode and queue count; nothing is held after reset
// a stalled response side fills the queue and then holds off requests
module source_text_tokenizer_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stt_pkg::stt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stt_pkg::stt_rsp_type rsp_data
);
   import stt_pkg::*;

   `include "source_text_tokenizer_core_assert.svh"

   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_start_ff, held_start_in;

   stt_rsp_type q_ff [3];
   stt_rsp_type q_in [3];
   stt_rsp_type q_sh [3];
   logic [1:0]  count_ff, count_in;

   logic        accept, pop;
   logic [1:0]  avail, push_n;

   logic [7:0]  c;
   logic        eos;

   // outcome of the byte seen from between tokens
   logic        idle_emit, idle_hold;
   logic [1:0]  idle_mode;
   stt_rsp_type idle_res;

   logic        lead_valid, use_idle;
   stt_rsp_type lead_res;
   stt_rsp_type r0, r1;
   logic [1:0]  n;
   logic        word_start;

   assign c   = req_data.src_byte;
   assign eos = req_data.end_of_source;

   assign pop       = rsp_valid && rsp_ready;
   assign avail     = count_ff - {1'b0, pop};
   assign req_ready = (avail < 2'd2);
   assign accept    = req_valid && req_ready;
   assign push_n    = accept ? n : 2'd0;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = q_ff[0];

   always_comb begin
      idle_emit = 1'b0;
      idle_hold = 1'b0;
      idle_mode = MODE_IDLE;
      idle_res  = mk_rsp(c, 1'b1, 1'b1, KIND_WORD, 1'b0);
      if (is_ws(c)) begin
         idle_emit = 1'b0;
      end else if (c == CH_QUOTE) begin
         idle_emit = 1'b1;
         idle_res  = mk_rsp(c, 1'b1, eos, KIND_STRING, eos);
         idle_mode = eos ? MODE_IDLE : MODE_STR;
      end else if (is_pair_first(c)) begin
         // lone & and | fall back to word bytes
         idle_res  = mk_rsp(c, 1'b1, 1'b1, is_punct(c) ? KIND_PUNCT : KIND_WORD, 1'b0);
         idle_emit = eos;
         idle_hold = !eos;
         idle_mode = eos ? MODE_IDLE : MODE_PEND;
      end else if (is_punct(c)) begin
         idle_emit = 1'b1;
         idle_res  = mk_rsp(c, 1'b1, 1'b1, KIND_PUNCT, 1'b0);
      end else begin
         idle_emit = eos;
         idle_hold = !eos;
         idle_mode = eos ? MODE_IDLE : MODE_WORD;
      end
   end

   always_comb begin
      n             = 2'd0;
      r0            = idle_res;
      r1            = idle_res;
      lead_valid    = 1'b0;
      lead_res      = idle_res;
      use_idle      = 1'b0;
      mode_in       = mode_ff;
      held_byte_in  = held_byte_ff;
      held_start_in = held_start_ff;
      word_start    = (mode_ff == MODE_PEND) ? 1'b1 : held_start_ff;

      unique case (mode_ff) inside
         MODE_IDLE: begin
            use_idle = 1'b1;
         end
         MODE_STR: begin
            n       = 2'd1;
            r0      = mk_rsp(c, 1'b0, (c == CH_QUOTE) || eos, KIND_STRING,
                             (c != CH_QUOTE) && eos);
            mode_in = ((c == CH_QUOTE) || eos) ? MODE_IDLE : MODE_STR;
         end
         MODE_WORD, MODE_PEND: begin
            if (mode_ff == MODE_PEND && pair_forms(held_byte_ff, c)) begin
               n       = 2'd2;
               r0      = mk_rsp(held_byte_ff, 1'b1, 1'b0, KIND_PAIR, 1'b0);
               r1      = mk_rsp(c, 1'b0, 1'b1, KIND_PAIR, 1'b0);
               mode_in = MODE_IDLE;
            end else if (mode_ff == MODE_PEND && is_punct(held_byte_ff)) begin
               lead_valid = 1'b1;
               lead_res   = mk_rsp(held_byte_ff, 1'b1, 1'b1, KIND_PUNCT, 1'b0);
               use_idle   = 1'b1;
            end else if (is_ws(c)) begin
               n       = 2'd1;
               r0      = mk_rsp(held_byte_ff, word_start, 1'b1, KIND_WORD, 1'b0);
               mode_in = MODE_IDLE;
            end else if (c == CH_QUOTE || is_punct(c)) begin
               lead_valid = 1'b1;
               lead_res   = mk_rsp(held_byte_ff, word_start, 1'b1, KIND_WORD, 1'b0);
               use_idle   = 1'b1;
            end else begin
               // word continues: the held byte goes out, the new one is held, or goes out too at end of source
               r0 = mk_rsp(held_byte_ff, word_start, 1'b0, KIND_WORD, 1'b0);
               r1 = mk_rsp(c, 1'b0, 1'b1, KIND_WORD, 1'b0);
               if (eos) begin
                  n       = 2'd2;
                  mode_in = MODE_IDLE;
               end else begin
                  n             = 2'd1;
                  mode_in       = MODE_WORD;
                  held_byte_in  = c;
                  held_start_in = 1'b0;
               end
            end
         end
         default: begin
            use_idle = 1'b1;
         end
      endcase

      if (use_idle) begin
         mode_in = idle_mode;
         if (idle_hold) begin
            held_byte_in  = c;
            held_start_in = 1'b1;
         end
         if (lead_valid) begin
            r0 = lead_res;
            r1 = idle_res;
            n  = idle_emit ? 2'd2 : 2'd1;
         end else begin
            r0 = idle_res;
            n  = idle_emit ? 2'd1 : 2'd0;
         end
      end

      if (eos) begin
         mode_in = MODE_IDLE;
      end

      r0.last_of_run = (n == 2'd1);
      r1.last_of_run = 1'b1;
   end

   // shift queue: head always in slot 0, new responses appended after survivors
   always_comb begin
      q_sh[0] = pop ? q_ff[1] : q_ff[0];
      q_sh[1] = pop ? q_ff[2] : q_ff[1];
      q_sh[2] = q_ff[2];
      for (int i = 0; i < 3; i++) begin
         q_in[i] = q_sh[i];
         if (accept && n != 2'd0 && avail == 2'(i)) begin
            q_in[i] = r0;
         end
         if (accept && n == 2'd2 && (avail + 2'd1) == 2'(i)) begin
            q_in[i] = r1;
         end
      end
      count_in = avail + push_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            mode_ff <= mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         q_ff[i] <= q_in[i];
      end
      if (accept) begin
         held_byte_ff  <= held_byte_in;
         held_start_ff <= held_start_in;
      end
   end

   `STT_ASSERT_NXT(a_eos_to_idle, accept && eos, mode_ff == MODE_IDLE)
   `STT_ASSERT_IMP(a_run_tail_queued, rsp_valid && !q_ff[0].last_of_run, count_ff >= 2'd2)
   `STT_ASSERT_IMP(a_unterm_string, rsp_valid && rsp_data.unterminated,
                   rsp_data.token_end && rsp_data.token_kind == KIND_STRING)
   `STT_ASSERT_IMP(a_no_overflow, accept, ({1'b0, avail} + {1'b0, n}) <= 3'd3)

endmodule
